// File: src/psgc_pkg.sv
// shared types and constants for the polynomial surface ground classifier
package psgc_pkg;

  localparam int unsigned COORD_W    = 24;
  localparam int unsigned CLASS_W    = 8;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned COEF_W     = 48;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned OUTCOME_W  = 2;
  localparam int unsigned MONO_W     = 2 * COORD_W;
  localparam int unsigned LO_W       = 32;
  localparam int unsigned HI_W       = COEF_W - LO_W;
  localparam int unsigned FRAC_W     = 32;
  localparam int unsigned SUM_W      = 100;

  // partial product widths
  localparam int unsigned PP_LL_W  = 2 * LO_W;
  localparam int unsigned PP_MIX_W = HI_W + LO_W + 1;
  localparam int unsigned PP_HH_W  = 2 * HI_W;
  localparam int unsigned PP_LLO_W = LO_W + 1 + COORD_W;
  localparam int unsigned PP_LHI_W = HI_W + COORD_W;

  localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_W - 1);

  localparam logic signed [COORD_W-1:0] SURF_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] SURF_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  localparam logic [CLASS_W-1:0] GROUND_CODE      = 8'd3;
  localparam logic [CLASS_W-1:0] ALL_CLASSES_CODE = 8'd0;
  localparam logic [THR_W-1:0]   THR_RESET        = 16'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD  = 3'd0,
    CFG_SELECT     = 3'd1,
    CFG_COEF_CONST = 3'd2,
    CFG_COEF_Y     = 3'd3,
    CFG_COEF_Y2    = 3'd4,
    CFG_COEF_X     = 3'd5,
    CFG_COEF_XY    = 3'd6,
    CFG_COEF_X2    = 3'd7
  } cfg_idx_e;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_KEEP    = 2'd0,
    OUT_UNCLASS = 2'd1,
    OUT_GROUND  = 2'd2
  } outcome_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic        [CLASS_W-1:0] point_class;
  } in_item_t;

  typedef struct packed {
    logic        [OUTCOME_W-1:0] outcome;
    logic signed [COORD_W-1:0]   surface_height;
  } out_item_t;

  typedef struct packed {
    logic signed [THR_W-1:0]  ground_threshold;
    logic        [CLASS_W-1:0] select_class;
    logic signed [COEF_W-1:0] coef_const;
    logic signed [COEF_W-1:0] coef_y;
    logic signed [COEF_W-1:0] coef_y2;
    logic signed [COEF_W-1:0] coef_x;
    logic signed [COEF_W-1:0] coef_xy;
    logic signed [COEF_W-1:0] coef_x2;
  } cfg_t;

  // fields that ride along with the arithmetic
  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic        [CLASS_W-1:0] cls;
  } side_t;

  // coefficient times 48-bit monomial, split into four partial products
  typedef struct packed {
    logic        [PP_LL_W-1:0]  ll;
    logic signed [PP_MIX_W-1:0] lh;
    logic signed [PP_MIX_W-1:0] hl;
    logic signed [PP_HH_W-1:0]  hh;
  } quad_pp_t;

  // coefficient times 24-bit coordinate, split into two partial products
  typedef struct packed {
    logic signed [PP_LLO_W-1:0] lo;
    logic signed [PP_LHI_W-1:0] hi;
  } lin_pp_t;

  typedef struct packed {
    quad_pp_t         y2;
    quad_pp_t         xy;
    quad_pp_t         x2;
    lin_pp_t          y;
    lin_pp_t          x;
    logic [SUM_W-1:0] t0;
  } pp_bundle_t;

endpackage

// File: src/psgc_mult.sv
// monomial and partial product stages of the surface evaluation
module psgc_mult (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  psgc_pkg::cfg_t        cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  psgc_pkg::in_item_t    in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output psgc_pkg::pp_bundle_t  out_pp_o,
  output psgc_pkg::side_t       out_side_o
);

  function automatic psgc_pkg::quad_pp_t quad_pp(
    input logic signed [psgc_pkg::COEF_W-1:0] c,
    input logic signed [psgc_pkg::MONO_W-1:0] m
  );
    psgc_pkg::quad_pp_t r;
    logic signed [psgc_pkg::HI_W-1:0] c_hi;
    logic signed [psgc_pkg::HI_W-1:0] m_hi;
    logic [psgc_pkg::LO_W-1:0]        c_lo;
    logic [psgc_pkg::LO_W-1:0]        m_lo;
    c_hi = c[psgc_pkg::COEF_W-1:psgc_pkg::LO_W];
    m_hi = m[psgc_pkg::MONO_W-1:psgc_pkg::LO_W];
    c_lo = c[psgc_pkg::LO_W-1:0];
    m_lo = m[psgc_pkg::LO_W-1:0];
    r.ll = c_lo * m_lo;
    r.lh = $signed({1'b0, c_lo}) * m_hi;
    r.hl = c_hi * $signed({1'b0, m_lo});
    r.hh = c_hi * m_hi;
    return r;
  endfunction

  function automatic psgc_pkg::lin_pp_t lin_pp(
    input logic signed [psgc_pkg::COEF_W-1:0]  c,
    input logic signed [psgc_pkg::COORD_W-1:0] p
  );
    psgc_pkg::lin_pp_t r;
    logic signed [psgc_pkg::HI_W-1:0] c_hi;
    logic [psgc_pkg::LO_W-1:0]        c_lo;
    c_hi = c[psgc_pkg::COEF_W-1:psgc_pkg::LO_W];
    c_lo = c[psgc_pkg::LO_W-1:0];
    r.lo = $signed({1'b0, c_lo}) * p;
    r.hi = c_hi * p;
    return r;
  endfunction

  logic                               s1_valid_q, s2_valid_q;
  logic                               rdy1, rdy2;
  logic signed [psgc_pkg::COORD_W-1:0] x1_q, y1_q;
  logic signed [psgc_pkg::MONO_W-1:0]  xx1_d, xy1_d, yy1_d;
  logic signed [psgc_pkg::MONO_W-1:0]  xx1_q, xy1_q, yy1_q;
  psgc_pkg::side_t                     side1_q, side2_q;
  psgc_pkg::pp_bundle_t                pp2_d, pp2_q;

  assign rdy2       = ~s2_valid_q | out_ready_i;
  assign rdy1       = ~s1_valid_q | rdy2;
  assign in_ready_o = rdy1;

  always_comb begin
    xx1_d = in_item_i.point_x * in_item_i.point_x;
    xy1_d = in_item_i.point_x * in_item_i.point_y;
    yy1_d = in_item_i.point_y * in_item_i.point_y;
  end

  always_comb begin
    pp2_d.y2 = quad_pp(cfg_i.coef_y2, yy1_q);
    pp2_d.xy = quad_pp(cfg_i.coef_xy, xy1_q);
    pp2_d.x2 = quad_pp(cfg_i.coef_x2, xx1_q);
    pp2_d.y  = lin_pp(cfg_i.coef_y, y1_q);
    pp2_d.x  = lin_pp(cfg_i.coef_x, x1_q);
    // constant term with the rounding half folded in
    pp2_d.t0 = {{(psgc_pkg::SUM_W-psgc_pkg::COEF_W){cfg_i.coef_const[psgc_pkg::COEF_W-1]}},
                cfg_i.coef_const} + psgc_pkg::HALF;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (rdy1) s1_valid_q <= in_valid_i;
      if (rdy2) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      x1_q       <= in_item_i.point_x;
      y1_q       <= in_item_i.point_y;
      xx1_q      <= xx1_d;
      xy1_q      <= xy1_d;
      yy1_q      <= yy1_d;
      side1_q.z   <= in_item_i.point_z;
      side1_q.cls <= in_item_i.point_class;
    end
    if (rdy2 && s1_valid_q) begin
      pp2_q   <= pp2_d;
      side2_q <= side1_q;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_pp_o    = pp2_q;
  assign out_side_o  = side2_q;

endmodule

// File: src/psgc_accum.sv
// adder stages that sum the partial products into the q.32 surface value
module psgc_accum (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  psgc_pkg::pp_bundle_t            in_pp_i,
  input  psgc_pkg::side_t                 in_side_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [psgc_pkg::SUM_W-1:0]      out_sum_o,
  output psgc_pkg::side_t                 out_side_o
);

  localparam int unsigned NSTG = 5;
  localparam int unsigned SW   = psgc_pkg::SUM_W;

  // low half: ll + hl << 32
  function automatic logic [SW-1:0] quad_lo(input psgc_pkg::quad_pp_t p);
    logic [SW-1:0] a, b;
    a = {{(SW-psgc_pkg::PP_LL_W){1'b0}}, p.ll};
    b = {{(SW-psgc_pkg::PP_MIX_W-psgc_pkg::LO_W){p.hl[psgc_pkg::PP_MIX_W-1]}},
         p.hl, {psgc_pkg::LO_W{1'b0}}};
    return a + b;
  endfunction

  // high half: lh << 32 + hh << 64
  function automatic logic [SW-1:0] quad_hi(input psgc_pkg::quad_pp_t p);
    logic [SW-1:0] a, b;
    a = {{(SW-psgc_pkg::PP_MIX_W-psgc_pkg::LO_W){p.lh[psgc_pkg::PP_MIX_W-1]}},
         p.lh, {psgc_pkg::LO_W{1'b0}}};
    b = {{(SW-psgc_pkg::PP_HH_W-2*psgc_pkg::LO_W){p.hh[psgc_pkg::PP_HH_W-1]}},
         p.hh, {(2*psgc_pkg::LO_W){1'b0}}};
    return a + b;
  endfunction

  function automatic logic [SW-1:0] lin_sum(input psgc_pkg::lin_pp_t p);
    logic [SW-1:0] a, b;
    a = {{(SW-psgc_pkg::PP_LLO_W){p.lo[psgc_pkg::PP_LLO_W-1]}}, p.lo};
    b = {{(SW-psgc_pkg::PP_LHI_W-psgc_pkg::LO_W){p.hi[psgc_pkg::PP_LHI_W-1]}},
         p.hi, {psgc_pkg::LO_W{1'b0}}};
    return a + b;
  endfunction

  logic [NSTG-1:0] valid_q;
  logic [NSTG-1:0] rdy;
  psgc_pkg::side_t side_q [NSTG];

  // stage 3
  logic [SW-1:0] y2a_q, y2b_q, xya_q, xyb_q, x2a_q, x2b_q, ty3_q, tx3_q, t03_q;
  // stage 4
  logic [SW-1:0] ty2_q, txy_q, tx2_q, ty4_q, tx4_q, t04_q;
  // stage 5
  logic [SW-1:0] p0_q, p1_q, p25_q;
  // stage 6
  logic [SW-1:0] p01_q, p26_q;
  // stage 7
  logic [SW-1:0] total_q;

  always_comb begin
    rdy[NSTG-1] = ~valid_q[NSTG-1] | out_ready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = ~valid_q[k] | rdy[k+1];
    end
  end

  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) valid_q[0] <= in_valid_i;
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      y2a_q     <= quad_lo(in_pp_i.y2);
      y2b_q     <= quad_hi(in_pp_i.y2);
      xya_q     <= quad_lo(in_pp_i.xy);
      xyb_q     <= quad_hi(in_pp_i.xy);
      x2a_q     <= quad_lo(in_pp_i.x2);
      x2b_q     <= quad_hi(in_pp_i.x2);
      ty3_q     <= lin_sum(in_pp_i.y);
      tx3_q     <= lin_sum(in_pp_i.x);
      t03_q     <= in_pp_i.t0;
      side_q[0] <= in_side_i;
    end
    if (rdy[1] && valid_q[0]) begin
      ty2_q     <= y2a_q + y2b_q;
      txy_q     <= xya_q + xyb_q;
      tx2_q     <= x2a_q + x2b_q;
      ty4_q     <= ty3_q;
      tx4_q     <= tx3_q;
      t04_q     <= t03_q;
      side_q[1] <= side_q[0];
    end
    if (rdy[2] && valid_q[1]) begin
      p0_q      <= t04_q + ty4_q;
      p1_q      <= ty2_q + tx4_q;
      p25_q     <= txy_q + tx2_q;
      side_q[2] <= side_q[1];
    end
    if (rdy[3] && valid_q[2]) begin
      p01_q     <= p0_q + p1_q;
      p26_q     <= p25_q;
      side_q[3] <= side_q[2];
    end
    if (rdy[4] && valid_q[3]) begin
      total_q   <= p01_q + p26_q;
      side_q[4] <= side_q[3];
    end
  end

  assign out_valid_o = valid_q[NSTG-1];
  assign out_sum_o   = total_q;
  assign out_side_o  = side_q[NSTG-1];

endmodule

// File: src/psgc_decide.sv
// saturation, ground test and class decision, with the output register
module psgc_decide (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  psgc_pkg::cfg_t              cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [psgc_pkg::SUM_W-1:0]  in_sum_i,
  input  psgc_pkg::side_t             in_side_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output psgc_pkg::out_item_t         out_item_o
);

  localparam int unsigned CW  = psgc_pkg::COORD_W;
  localparam int unsigned TOP = psgc_pkg::FRAC_W + CW - 1;

  logic                     s8_valid_q, s9_valid_q;
  logic                     rdy8, rdy9;
  logic [psgc_pkg::SUM_W-1:TOP] upper;
  logic                     in_range;
  logic signed [CW-1:0]     surf8_d, surf8_q;
  psgc_pkg::side_t          side8_q;
  logic [CW:0]              diff;
  logic [CW:0]              thr_ext;
  logic                     low;
  psgc_pkg::outcome_e       outcome;
  psgc_pkg::out_item_t      out_d, out_q;
  logic [psgc_pkg::CLASS_W-1:0] cls9_q;

  assign rdy9       = ~s9_valid_q | out_ready_i;
  assign rdy8       = ~s8_valid_q | rdy9;
  assign in_ready_o = rdy8;

  // integer part fits when all bits from the 24-bit sign upward agree
  always_comb begin
    upper    = in_sum_i[psgc_pkg::SUM_W-1:TOP];
    in_range = (&upper) | ~(|upper);
    if (in_range) begin
      surf8_d = in_sum_i[TOP:psgc_pkg::FRAC_W];
    end else if (in_sum_i[psgc_pkg::SUM_W-1]) begin
      surf8_d = psgc_pkg::SURF_MIN;
    end else begin
      surf8_d = psgc_pkg::SURF_MAX;
    end
  end

  always_comb begin
    diff    = {side8_q.z[CW-1], side8_q.z} - {surf8_q[CW-1], surf8_q};
    thr_ext = {{(CW+1-psgc_pkg::THR_W){cfg_i.ground_threshold[psgc_pkg::THR_W-1]}},
               cfg_i.ground_threshold};
    low     = $signed(diff) <= $signed(thr_ext);
    outcome = psgc_pkg::OUT_KEEP;
    if (cfg_i.select_class == psgc_pkg::ALL_CLASSES_CODE) begin
      if (low) begin
        outcome = psgc_pkg::OUT_GROUND;
      end else if (side8_q.cls == psgc_pkg::GROUND_CODE) begin
        outcome = psgc_pkg::OUT_UNCLASS;
      end
    end else if (side8_q.cls == cfg_i.select_class) begin
      outcome = low ? psgc_pkg::OUT_GROUND : psgc_pkg::OUT_UNCLASS;
    end
    out_d.outcome        = outcome;
    out_d.surface_height = surf8_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_valid_q <= 1'b0;
      s9_valid_q <= 1'b0;
    end else begin
      if (rdy8) s8_valid_q <= in_valid_i;
      if (rdy9) s9_valid_q <= s8_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy8 && in_valid_i) begin
      surf8_q <= surf8_d;
      side8_q <= in_side_i;
    end
    if (rdy9 && s8_valid_q) begin
      out_q  <= out_d;
      cls9_q <= side8_q.cls;
    end
  end

  assign out_valid_o = s9_valid_q;
  assign out_item_o  = out_q;

  a_outcome_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s9_valid_q |-> out_q.outcome != 2'd3)
    else $error("outcome register holds an undefined code");

  a_single_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s9_valid_q && cfg_i.select_class != psgc_pkg::ALL_CLASSES_CODE
      && out_q.outcome != psgc_pkg::OUT_KEEP |-> cls9_q == cfg_i.select_class)
    else $error("class changed on a return that is not selected");

  a_all_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s9_valid_q && cfg_i.select_class == psgc_pkg::ALL_CLASSES_CODE
      && out_q.outcome == psgc_pkg::OUT_UNCLASS |-> cls9_q == psgc_pkg::GROUND_CODE)
    else $error("all-classes mode cleared a return that was not ground");

endmodule

// File: src/poly_surface_ground_classifier.sv
// top level of the polynomial surface ground classifier
//
// Input channel: in_item_i carries one lidar return (x, y, z, class) and is
// taken at a clock edge where in_valid_i is high and in_stall_o is low.
// Output channel: out_item_o carries the outcome code and the rounded,
// saturated surface height; it is taken where out_valid_o is high and
// out_stall_i is low. Exactly one result leaves for each item, in order.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (threshold, select class, six Q16.32 coefficients); the user must write
// only while idle, and the block does not enforce it. The result passes
// nine register stages (squares and cross product, 32x32 partial products,
// five levels of wide adds, saturation, decision and output).
// Throughput: one item per cycle, sustained, for as long as the receiver
// takes results. When the receiver stalls, stages fill up from the output
// back and in_stall_o rises only once every stage holds an item.
// Reset clears all valid bits and returns the registers to threshold 50,
// select class 0 and zero coefficients.
module poly_surface_ground_classifier (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  psgc_pkg::in_item_t                 in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output psgc_pkg::out_item_t                out_item_o,
  input  logic                               cfg_we_i,
  input  logic [psgc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [psgc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  psgc_pkg::cfg_t       cfg_q;
  logic                 in_ready;
  logic                 m_valid, m_ready;
  psgc_pkg::pp_bundle_t m_pp;
  psgc_pkg::side_t      m_side;
  logic                 a_valid, a_ready;
  logic [psgc_pkg::SUM_W-1:0] a_sum;
  psgc_pkg::side_t      a_side;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ground_threshold <= psgc_pkg::THR_RESET;
      cfg_q.select_class     <= '0;
      cfg_q.coef_const       <= '0;
      cfg_q.coef_y           <= '0;
      cfg_q.coef_y2          <= '0;
      cfg_q.coef_x           <= '0;
      cfg_q.coef_xy          <= '0;
      cfg_q.coef_x2          <= '0;
    end else if (cfg_we_i) begin
      unique case (psgc_pkg::cfg_idx_e'(cfg_idx_i))
        psgc_pkg::CFG_THRESHOLD:
          cfg_q.ground_threshold <= cfg_data_i[psgc_pkg::THR_W-1:0];
        psgc_pkg::CFG_SELECT:     cfg_q.select_class <= cfg_data_i[psgc_pkg::CLASS_W-1:0];
        psgc_pkg::CFG_COEF_CONST: cfg_q.coef_const   <= cfg_data_i[psgc_pkg::COEF_W-1:0];
        psgc_pkg::CFG_COEF_Y:     cfg_q.coef_y       <= cfg_data_i[psgc_pkg::COEF_W-1:0];
        psgc_pkg::CFG_COEF_Y2:    cfg_q.coef_y2      <= cfg_data_i[psgc_pkg::COEF_W-1:0];
        psgc_pkg::CFG_COEF_X:     cfg_q.coef_x       <= cfg_data_i[psgc_pkg::COEF_W-1:0];
        psgc_pkg::CFG_COEF_XY:    cfg_q.coef_xy      <= cfg_data_i[psgc_pkg::COEF_W-1:0];
        psgc_pkg::CFG_COEF_X2:    cfg_q.coef_x2      <= cfg_data_i[psgc_pkg::COEF_W-1:0];
        default:                  cfg_q              <= cfg_q;
      endcase
    end
  end

  psgc_mult u_mult (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item_i),
    .out_valid_o (m_valid),
    .out_ready_i (m_ready),
    .out_pp_o    (m_pp),
    .out_side_o  (m_side)
  );

  psgc_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (m_valid),
    .in_ready_o  (m_ready),
    .in_pp_i     (m_pp),
    .in_side_i   (m_side),
    .out_valid_o (a_valid),
    .out_ready_i (a_ready),
    .out_sum_o   (a_sum),
    .out_side_o  (a_side)
  );

  psgc_decide u_decide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (a_valid),
    .in_ready_o  (a_ready),
    .in_sum_i    (a_sum),
    .in_side_i   (a_side),
    .out_valid_o (out_valid_o),
    .out_ready_i (~out_stall_i),
    .out_item_o  (out_item_o)
  );

  assign in_stall_o = ~in_ready;

  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while the output side takes items");

endmodule
